[sv/speed_ramp_generator_unit_defines.svh]
// Assertion macros for the speed ramp generator unit.
// Each macro checks a property on the rising edge of clock, gated by reset.
// Included by the RTL files that carry assertions; no other dependencies.
`ifndef SPEED_RAMP_GENERATOR_UNIT_DEFINES_SVH
`define SPEED_RAMP_GENERATOR_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define SRG_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("speed ramp generator assertion failed");
`define SRG_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("speed ramp generator assertion failed");
`else
`define SRG_ASSERT_IMP(lbl, ante, cons)
`define SRG_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

[sv/srg_pkg.sv]
// Shared types and constants of the speed ramp generator unit.
// Used by srg_muldiv, speed_ramp_generator_unit and the testbench; depends on nothing.
`default_nettype none

package srg_pkg;

   localparam int DATA_W = 32;
   localparam int ELAPSED_W = 31;
   localparam int PROD_W = DATA_W + ELAPSED_W;
   localparam int STEP_W = 34;
   localparam int WIDE_W = 37;
   localparam int CMD_W = 3;
   localparam int MODE_W = 3;
   localparam int CSR_ADDR_W = 4;
   localparam int TIME_SCALE_DEFAULT = 1000000;

   localparam logic [STEP_W-1:0] STEP_CAP = STEP_W'(64'h2_0000_0000);

   localparam logic [CMD_W-1:0] CMD_UPDATE = 3'd0;
   localparam logic [CMD_W-1:0] CMD_BEGIN  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_END    = 3'd2;
   localparam logic [CMD_W-1:0] CMD_GOAL   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_BRAKE  = 3'd4;

   localparam logic [MODE_W-1:0] MODE_IDLE     = 3'd0;
   localparam logic [MODE_W-1:0] MODE_SLOPE    = 3'd1;
   localparam logic [MODE_W-1:0] MODE_CONSTANT = 3'd2;
   localparam logic [MODE_W-1:0] MODE_ENDING   = 3'd3;
   localparam logic [MODE_W-1:0] MODE_BRAKE    = 3'd4;

   localparam logic [1:0] REG_RAMP_RATE  = 2'd0;
   localparam logic [1:0] REG_BRAKE_RATE = 2'd1;
   localparam logic [1:0] REG_TOLERANCE  = 2'd2;

   typedef struct packed {
      logic busy;
      logic done;
   } srg_div_status_type;

endpackage

`default_nettype wire

[sv/srg_muldiv.sv]
// Shared multiply unit: step = rate * elapsed / TIME_SCALE, capped at STEP_CAP.
// One 33x32 multiplier forms the product, a reciprocal estimate and its back product,
// then a short compare and subtract loop fixes the quotient. Depends on srg_pkg.
`default_nettype none
`include "speed_ramp_generator_unit_defines.svh"

module srg_muldiv
   import srg_pkg::*;
#(
   parameter int TIME_SCALE = TIME_SCALE_DEFAULT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [DATA_W-1:0]    rate,
   input  wire logic [ELAPSED_W-1:0] elapsed,
   output srg_div_status_type        status,
   output logic [STEP_W-1:0]         step
);

   // The estimate never exceeds the true quotient and is short by at most eight.
   localparam int SH = $clog2(TIME_SCALE) + 1;
   localparam int RECIP_SH = 30;
   localparam int REM_W = 36;
   localparam int QW = STEP_W - 1;
   localparam int MA_W = QW;
   localparam int MP_W = MA_W + DATA_W;
   localparam logic [63:0] CAP_LIM = 64'(TIME_SCALE) << 33;
   localparam logic [63:0] RECIP_WIDE = (64'd1 << (SH + RECIP_SH)) / 64'(TIME_SCALE);
   localparam logic [DATA_W-1:0] RECIP = DATA_W'(RECIP_WIDE);
   localparam logic [DATA_W-1:0] DIVISOR = DATA_W'(TIME_SCALE);
   localparam logic [REM_W-1:0] TS_REM = REM_W'(TIME_SCALE);
   localparam logic [REM_W-1:0] REM_BOUND = REM_W'(64'(TIME_SCALE) * 64'd9);

   typedef enum logic [5:0] {
      D_IDLE = 6'b000001,
      D_PROD = 6'b000010,
      D_EST  = 6'b000100,
      D_BACK = 6'b001000,
      D_FIX  = 6'b010000,
      D_DONE = 6'b100000
   } div_state_type;

   div_state_type     state_ff, state_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [QW-1:0]     quot_ff, quot_in;
   logic              capped_ff, capped_in;
   logic [MA_W-1:0]   mul_a;
   logic [DATA_W-1:0] mul_b;
   logic [MP_W-1:0]   mul_p;
   logic [DATA_W-1:0] p_hi;
   logic              over_cap;

   assign mul_p    = MP_W'(mul_a) * MP_W'(mul_b);
   assign p_hi     = DATA_W'(prod_ff >> SH);
   assign over_cap = ({1'b0, prod_ff} >= CAP_LIM);

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         D_PROD: begin
            mul_a = MA_W'(rate);
            mul_b = DATA_W'(elapsed);
         end
         D_EST: begin
            mul_a = MA_W'(p_hi);
            mul_b = RECIP;
         end
         D_BACK: begin
            mul_a = quot_ff;
            mul_b = DIVISOR;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in  = state_ff;
      prod_in   = prod_ff;
      rem_in    = rem_ff;
      quot_in   = quot_ff;
      capped_in = capped_ff;
      unique case (state_ff)
         D_IDLE: begin
            if (start) begin
               state_in = D_PROD;
            end
         end
         D_PROD: begin
            prod_in  = mul_p[PROD_W-1:0];
            state_in = D_EST;
         end
         D_EST: begin
            quot_in   = mul_p[RECIP_SH +: QW];
            capped_in = over_cap;
            state_in  = over_cap ? D_DONE : D_BACK;
         end
         D_BACK: begin
            rem_in   = REM_W'(prod_ff - mul_p[PROD_W-1:0]);
            state_in = D_FIX;
         end
         D_FIX: begin
            if (rem_ff >= TS_REM) begin
               rem_in  = rem_ff - TS_REM;
               quot_in = quot_ff + QW'(1);
            end else begin
               state_in = D_DONE;
            end
         end
         D_DONE: begin
            state_in = D_IDLE;
         end
         default: begin
            state_in = D_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff   <= prod_in;
      rem_ff    <= rem_in;
      quot_ff   <= quot_in;
      capped_ff <= capped_in;
   end

   assign step = capped_ff ? STEP_CAP : STEP_W'(quot_ff);

   assign status.busy = (state_ff != D_IDLE);
   assign status.done = (state_ff == D_DONE);

   `SRG_ASSERT_IMP(a_start_when_idle, start, state_ff == D_IDLE)
   `SRG_ASSERT_IMP(a_fix_rem_bounded, state_ff == D_FIX, rem_ff < REM_BOUND)
   `SRG_ASSERT_NXT(a_done_single, state_ff == D_DONE, state_ff == D_IDLE)

endmodule

`default_nettype wire

[sv/speed_ramp_generator_unit.sv]
// Timing: an update tick in slope, ending or brake mode is computed by the shared multiplier
// sequence in srg_muldiv (S_LOAD, S_WAIT, then S_FIN; the fix steps are skipped when the
// step saturates); every other command goes straight to S_FIN. S_FIN commits the result
// once the response register is free. Throughput: one transaction at a time; req_tready
// rises together with rsp_tvalid, so a new one is taken only after the last is committed.
// Synchronous reset clears the mode, speeds, slope start, goal and registers at once.
`default_nettype none
`include "speed_ramp_generator_unit_defines.svh"

module speed_ramp_generator_unit
   import srg_pkg::*;
#(
   parameter int TIME_SCALE = TIME_SCALE_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [63:0]           req_tdata,   // timestamp_us [31:0], new_speed [63:32]
   input  wire logic [CMD_W-1:0]      req_tuser,   // command [2:0]
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [DATA_W-1:0]          rsp_tdata,   // speed [31:0]
   output logic [3:0]                 rsp_tuser,   // ramp_mode [2:0], time_error [3]
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [DATA_W-1:0]     csr_pwdata,
   output logic [DATA_W-1:0]          csr_prdata,
   output logic                       csr_pready
);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_LOAD = 4'b0010,
      S_WAIT = 4'b0100,
      S_FIN  = 4'b1000
   } srg_state_type;

   srg_state_type         state_ff, state_in;
   logic [DATA_W-1:0]     ramp_rate_ff, brake_rate_ff, tolerance_ff;
   logic [MODE_W-1:0]     mode_ff, mode_in;
   logic [DATA_W-1:0]     speed_ff, speed_in;
   logic [DATA_W-1:0]     start_speed_ff, start_speed_in;
   logic [DATA_W-1:0]     start_time_ff, start_time_in;
   logic [DATA_W-1:0]     goal_ff, goal_in;
   logic [CMD_W-1:0]      cmd_ff;
   logic [DATA_W-1:0]     ts_ff, ns_ff;
   logic [ELAPSED_W-1:0]  elapsed_ff;
   logic                  late_ff;
   logic                  rsp_valid_ff;
   logic [DATA_W-1:0]     rsp_speed_ff;
   logic [MODE_W-1:0]     rsp_mode_ff;
   logic                  rsp_late_ff;

   logic                  accept;
   logic                  needs_calc;
   logic [DATA_W-1:0]     elapsed_raw;
   logic                  commit;
   logic                  csr_write;
   logic [DATA_W-1:0]     rate_sel;
   srg_div_status_type    div_status;
   logic [STEP_W-1:0]     step;
   logic signed [WIDE_W-1:0] start_s, goal_s, tol_s, step_s, v_up, v_dn;

   assign accept      = req_tvalid && req_tready;
   assign req_tready  = (state_ff == S_IDLE);
   assign needs_calc  = (req_tuser == CMD_UPDATE) &&
                        ((mode_ff == MODE_SLOPE) || (mode_ff == MODE_ENDING) ||
                         (mode_ff == MODE_BRAKE));
   assign elapsed_raw = req_tdata[31:0] - start_time_ff;
   assign commit      = (state_ff == S_FIN) && (!rsp_valid_ff || rsp_tready);
   assign rate_sel    = (mode_ff == MODE_BRAKE) ? brake_rate_ff : ramp_rate_ff;

   srg_muldiv #(
      .TIME_SCALE(TIME_SCALE)
   ) u_muldiv (
      .clock  (clock),
      .reset  (reset),
      .start  (state_ff == S_LOAD),
      .rate   (rate_sel),
      .elapsed(elapsed_ff),
      .status (div_status),
      .step   (step)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = needs_calc ? S_LOAD : S_FIN;
            end
         end
         S_LOAD: state_in = S_WAIT;
         S_WAIT: begin
            if (div_status.done) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (commit) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign start_s = WIDE_W'(start_speed_ff);
   assign goal_s  = WIDE_W'(goal_ff);
   assign tol_s   = WIDE_W'(tolerance_ff);
   assign step_s  = WIDE_W'(step);
   assign v_up    = start_s + step_s;
   assign v_dn    = start_s - step_s;

   always_comb begin
      mode_in        = mode_ff;
      speed_in       = speed_ff;
      start_speed_in = start_speed_ff;
      start_time_in  = start_time_ff;
      goal_in        = goal_ff;
      unique case (cmd_ff)
         CMD_UPDATE: begin
            if (mode_ff == MODE_SLOPE) begin
               if (start_s + tol_s < goal_s) begin
                  if (v_up + tol_s > goal_s) begin
                     speed_in = goal_ff;
                     mode_in  = MODE_CONSTANT;
                  end else begin
                     speed_in = v_up[DATA_W-1:0];
                  end
               end else if (start_s > goal_s + tol_s) begin
                  if (v_dn < goal_s + tol_s) begin
                     speed_in = goal_ff;
                     mode_in  = MODE_CONSTANT;
                  end else begin
                     speed_in = v_dn[DATA_W-1:0];
                  end
               end else begin
                  speed_in = goal_ff;
                  mode_in  = MODE_CONSTANT;
               end
            end else if ((mode_ff == MODE_ENDING) || (mode_ff == MODE_BRAKE)) begin
               if (v_dn < tol_s) begin
                  speed_in = '0;
                  mode_in  = MODE_IDLE;
               end else begin
                  speed_in = v_dn[DATA_W-1:0];
               end
            end
         end
         CMD_BEGIN: begin
            if (mode_ff == MODE_IDLE) begin
               mode_in        = MODE_SLOPE;
               start_time_in  = ts_ff;
               start_speed_in = speed_ff;
            end
         end
         CMD_END, CMD_BRAKE: begin
            if ((mode_ff == MODE_SLOPE) || (mode_ff == MODE_CONSTANT)) begin
               mode_in        = (cmd_ff == CMD_END) ? MODE_ENDING : MODE_BRAKE;
               start_time_in  = ts_ff;
               start_speed_in = speed_ff;
            end
         end
         CMD_GOAL: begin
            goal_in = ns_ff;
            if ((mode_ff == MODE_SLOPE) || (mode_ff == MODE_CONSTANT)) begin
               mode_in        = MODE_SLOPE;
               start_time_in  = ts_ff;
               start_speed_in = speed_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         mode_ff        <= MODE_IDLE;
         speed_ff       <= '0;
         start_speed_ff <= '0;
         start_time_ff  <= '0;
         goal_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (commit) begin
            mode_ff        <= mode_in;
            speed_ff       <= speed_in;
            start_speed_ff <= start_speed_in;
            start_time_ff  <= start_time_in;
            goal_ff        <= goal_in;
            rsp_valid_ff   <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff     <= req_tuser;
         ts_ff      <= req_tdata[31:0];
         ns_ff      <= req_tdata[63:32];
         late_ff    <= needs_calc && elapsed_raw[DATA_W-1];
         elapsed_ff <= elapsed_raw[DATA_W-1] ? '0 : elapsed_raw[ELAPSED_W-1:0];
      end
      if (commit) begin
         rsp_speed_ff <= speed_in;
         rsp_mode_ff  <= mode_in;
         rsp_late_ff  <= late_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_speed_ff;
   assign rsp_tuser  = {rsp_late_ff, rsp_mode_ff};

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         ramp_rate_ff  <= '0;
         brake_rate_ff <= '0;
         tolerance_ff  <= '0;
      end else if (csr_write) begin
         unique case (csr_paddr[3:2])
            REG_RAMP_RATE:  ramp_rate_ff  <= csr_pwdata;
            REG_BRAKE_RATE: brake_rate_ff <= csr_pwdata;
            REG_TOLERANCE:  tolerance_ff  <= csr_pwdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_RAMP_RATE:  csr_prdata = ramp_rate_ff;
         REG_BRAKE_RATE: csr_prdata = brake_rate_ff;
         REG_TOLERANCE:  csr_prdata = tolerance_ff;
         default:        csr_prdata = '0;
      endcase
   end

   `SRG_ASSERT_IMP(a_div_idle_when_ready, req_tready, !div_status.busy)
   `SRG_ASSERT_NXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   `SRG_ASSERT_IMP(a_mode_legal, 1'b1, mode_ff <= MODE_BRAKE)

endmodule

`default_nettype wire

[tb/tb_speed_ramp_generator_unit.sv]
// Self-checking testbench for speed_ramp_generator_unit: ramp events go in on the
// req_ stream, predicted speed, mode and time error are compared with the rsp_ stream.
// Depends on srg_pkg and the speed_ramp_generator_unit RTL only.
`default_nettype none

module tb_speed_ramp_generator_unit
   import srg_pkg::*;
();

   localparam int TIME_SCALE = TIME_SCALE_DEFAULT;
   localparam int TOTAL_EVENTS = 1550;
   localparam int PHASE_EVENTS = 220;
   localparam int unsigned CYCLE_LIMIT = 1_500_000;

   typedef struct packed {
      logic [CMD_W-1:0] command;
      logic [31:0]      timestamp_us;
      logic [31:0]      new_speed;
   } ramp_event_type;

   typedef struct packed {
      logic [DATA_W-1:0] speed;
      logic [MODE_W-1:0] ramp_mode;
      logic              time_error;
   } ramp_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [63:0]           req_tdata = '0;     // timestamp_us [31:0], new_speed [63:32]
   logic [CMD_W-1:0]      req_tuser = '0;     // command [2:0]
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [DATA_W-1:0]     rsp_tdata;          // speed [31:0]
   logic [3:0]            rsp_tuser;          // ramp_mode [2:0], time_error [3]
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [DATA_W-1:0]     csr_pwdata = '0;
   logic [DATA_W-1:0]     csr_prdata;
   logic                  csr_pready;

   speed_ramp_generator_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   ramp_event_type  ramp_events[$];
   ramp_result_type ramp_forecast[$];
   ramp_event_type  offered;
   int unsigned  error_count = 0;
   int unsigned  cycle_count = 0;
   int unsigned  send_gap = 0;
   int unsigned  send_calm = 0;
   int unsigned  recv_stall = 0;
   int unsigned  recv_calm = 0;
   int unsigned  hold_left = 0;
   bit           long_hold_request = 1'b0;
   int           issued = 0;
   logic [31:0]  now_us = '0;
   logic [31:0]  anchor_us = '0;

   logic [31:0]       cfg_ramp_rate = '0;
   logic [31:0]       cfg_brake_rate = '0;
   logic [31:0]       cfg_tolerance = '0;
   logic [MODE_W-1:0] mode_now = MODE_IDLE;
   logic [31:0]       speed_now = '0;
   logic [31:0]       slope_speed = '0;
   logic [31:0]       slope_t0 = '0;
   logic [31:0]       goal_speed = '0;

   function automatic void start_slope(input logic [MODE_W-1:0] next_mode,
                                       input logic [31:0] stamp);
      mode_now = next_mode;
      slope_t0 = stamp;
      slope_speed = speed_now;
   endfunction

   function automatic longint ramp_change(input logic [31:0] rate, input logic [31:0] stamp,
                                          output bit late);
      logic [31:0] elapsed;
      logic [63:0] delta;
      elapsed = stamp - slope_t0;
      late = elapsed[31];
      if (late) elapsed = '0;
      delta = (64'(rate) * 64'(elapsed)) / 64'(TIME_SCALE);
      if (delta > 64'h2_0000_0000) delta = 64'h2_0000_0000;
      return longint'(delta);
   endfunction

   function automatic ramp_result_type step_ramp(input ramp_event_type ev);
      ramp_result_type res;
      bit           late;
      longint       tol;
      longint       start;
      longint       goal;
      longint       v;
      late = 1'b0;
      tol = longint'({32'd0, cfg_tolerance});
      start = longint'({32'd0, slope_speed});
      goal = longint'({32'd0, goal_speed});
      case (ev.command)
         CMD_UPDATE: begin
            if (mode_now == MODE_SLOPE) begin
               if (start + tol < goal) begin
                  v = start + ramp_change(cfg_ramp_rate, ev.timestamp_us, late);
                  if (v + tol > goal) begin
                     speed_now = goal_speed;
                     mode_now = MODE_CONSTANT;
                  end else begin
                     speed_now = v[31:0];
                  end
               end else if (start > goal + tol) begin
                  v = start - ramp_change(cfg_ramp_rate, ev.timestamp_us, late);
                  if (v < goal + tol) begin
                     speed_now = goal_speed;
                     mode_now = MODE_CONSTANT;
                  end else begin
                     speed_now = v[31:0];
                  end
               end else begin
                  void'(ramp_change(cfg_ramp_rate, ev.timestamp_us, late));
                  speed_now = goal_speed;
                  mode_now = MODE_CONSTANT;
               end
            end else if (mode_now == MODE_ENDING || mode_now == MODE_BRAKE) begin
               v = start - ramp_change((mode_now == MODE_ENDING) ? cfg_ramp_rate
                                       : cfg_brake_rate, ev.timestamp_us, late);
               if (v < tol) begin
                  speed_now = '0;
                  mode_now = MODE_IDLE;
               end else begin
                  speed_now = v[31:0];
               end
            end
         end
         CMD_BEGIN: begin
            if (mode_now == MODE_IDLE) start_slope(MODE_SLOPE, ev.timestamp_us);
         end
         CMD_END: begin
            if (mode_now == MODE_SLOPE || mode_now == MODE_CONSTANT)
               start_slope(MODE_ENDING, ev.timestamp_us);
         end
         CMD_GOAL: begin
            goal_speed = ev.new_speed;
            if (mode_now == MODE_SLOPE || mode_now == MODE_CONSTANT)
               start_slope(MODE_SLOPE, ev.timestamp_us);
         end
         CMD_BRAKE: begin
            if (mode_now == MODE_SLOPE || mode_now == MODE_CONSTANT)
               start_slope(MODE_BRAKE, ev.timestamp_us);
         end
         default: ;
      endcase
      res.speed = speed_now;
      res.ramp_mode = mode_now;
      res.time_error = late;
      return res;
   endfunction

   // Mostly short gaps, a few long ones, and now and then a run with no gaps at all.
   function automatic int unsigned draw_gap(inout int unsigned calm_left);
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      if ($urandom_range(0, 39) == 0) begin
         calm_left = $urandom_range(20, 80);
         return 0;
      end
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return 0;
         4, 5, 6, 7: return $urandom_range(1, 3);
         8: return $urandom_range(4, 12);
         default: return $urandom_range(20, 60);
      endcase
   endfunction

   always @(posedge clock) begin : event_driver
      logic offer;
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
      end else begin
         offer = req_tvalid;
         if (req_tvalid && req_tready) begin
            ramp_forecast.push_back(step_ramp(offered));
            offer = 1'b0;
            send_gap = draw_gap(send_calm);
         end
         if (!offer) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (ramp_events.size() > 0) begin
               offered = ramp_events.pop_front();
               req_tdata <= {offered.new_speed, offered.timestamp_us};
               req_tuser <= offered.command;
               offer = 1'b1;
            end
         end
         req_tvalid <= offer;
      end
   end

   always @(posedge clock) begin : result_pacer
      if (reset) begin
         rsp_tready <= 1'b0;
         recv_stall = 0;
         hold_left = 0;
      end else if (long_hold_request) begin
         long_hold_request = 1'b0;
         hold_left = $urandom_range(300, 500);
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (recv_stall > 0) begin
         recv_stall--;
         rsp_tready <= 1'b0;
      end else begin
         recv_stall = draw_gap(recv_calm);
         rsp_tready <= (recv_stall == 0);
      end
   end

   always @(posedge clock) begin : result_checker
      ramp_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (ramp_forecast.size() == 0) begin
            $error("unexpected result transaction: speed %h", rsp_tdata);
            error_count++;
         end else begin
            want = ramp_forecast.pop_front();
            if (rsp_tdata !== want.speed) begin
               $error("speed: expected %h, got %h", want.speed, rsp_tdata);
               error_count++;
            end
            if (rsp_tuser[2:0] !== want.ramp_mode) begin
               $error("ramp_mode: expected %0d, got %0d", want.ramp_mode, rsp_tuser[2:0]);
               error_count++;
            end
            if (rsp_tuser[3] !== want.time_error) begin
               $error("time_error: expected %0d, got %0d", want.time_error, rsp_tuser[3]);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_speed_ramp_generator_unit: FAIL");
         $finish;
      end
   end

   task automatic write_csr(input logic [1:0] index, input logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_ADDR_W'({index, 2'b00});
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (index)
         REG_RAMP_RATE:  cfg_ramp_rate = value;
         REG_BRAKE_RATE: cfg_brake_rate = value;
         REG_TOLERANCE:  cfg_tolerance = value;
         default: ;
      endcase
   endtask

   task automatic program_rates(input logic [31:0] ramp, input logic [31:0] brake,
                                input logic [31:0] tol);
      write_csr(REG_RAMP_RATE, ramp);
      write_csr(REG_BRAKE_RATE, brake);
      write_csr(REG_TOLERANCE, tol);
   endtask

   task automatic drain_results();
      do @(negedge clock);
      while (ramp_events.size() != 0 || req_tvalid || ramp_forecast.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic push_event(input logic [CMD_W-1:0] cmd, input logic [31:0] stamp,
                             input logic [31:0] speed);
      ramp_events.push_back('{command: cmd, timestamp_us: stamp, new_speed: speed});
      issued++;
   endtask

   function automatic logic [31:0] rand_magnitude();
      return $urandom >> $urandom_range(0, 31);
   endfunction

   function automatic logic [31:0] pick_goal();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return $urandom >> $urandom_range(0, 16);
      endcase
   endfunction

   function automatic logic [31:0] next_stamp();
      case ($urandom_range(0, 9))
         0: ;
         1, 2, 3: now_us = now_us + 32'($urandom_range(1, 5000));
         4, 5, 6, 7: now_us = now_us + 32'($urandom_range(1, 3_000_000));
         8: now_us = now_us + 32'($urandom_range(0, 32'h7FFF_FFFF));
         default: now_us = now_us + 32'($urandom_range(0, 200_000_000));
      endcase
      return now_us;
   endfunction

   task automatic push_update();
      if ($urandom_range(0, 11) == 0)
         push_event(CMD_UPDATE, anchor_us - 32'($urandom_range(1, 2_000_000)), $urandom);
      else
         push_event(CMD_UPDATE, next_stamp(), $urandom);
   endtask

   task automatic push_anchored(input logic [CMD_W-1:0] cmd, input logic [31:0] speed);
      anchor_us = next_stamp();
      push_event(cmd, anchor_us, speed);
   endtask

   task automatic push_ramp_episode();
      if ($urandom_range(0, 3) != 0) push_anchored(CMD_GOAL, pick_goal());
      push_anchored(CMD_BEGIN, $urandom);
      repeat ($urandom_range(1, 6)) push_update();
      if ($urandom_range(0, 2) == 0) begin
         push_anchored(CMD_GOAL, pick_goal());
         repeat ($urandom_range(1, 5)) push_update();
      end
      case ($urandom_range(0, 3))
         0: push_anchored(CMD_END, $urandom);
         1: push_anchored(CMD_BRAKE, $urandom);
         default: ;
      endcase
      repeat ($urandom_range(1, 6)) push_update();
      if ($urandom_range(0, 4) == 0)
         push_event(CMD_W'($urandom_range(0, 7)), $urandom, $urandom);
   endtask

   initial begin : stimulus
      int phase;
      int phase_start;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      program_rates(32'h4000_0000, 32'h8000_0000, 32'h0001_0000);
      push_event(CMD_UPDATE, 32'd0, 32'd0);
      push_event(CMD_END, 32'd10, 32'hFFFF_FFFF);
      push_event(CMD_BRAKE, 32'd20, 32'd0);
      push_event(CMD_GOAL, 32'd30, 32'hFFFF_FFFF);
      push_event(CMD_BEGIN, 32'd1000, 32'd0);
      push_event(CMD_BEGIN, 32'd2000, 32'd0);
      push_event(CMD_UPDATE, 32'd999, 32'd0);
      push_event(CMD_UPDATE, 32'd1_001_000, 32'd0);
      push_event(CMD_UPDATE, 32'h8000_03E8, 32'd0);
      push_event(CMD_UPDATE, 32'h8000_03E7, 32'd0);
      push_event(CMD_UPDATE, 32'h8000_1000, 32'd0);
      push_event(CMD_GOAL, 32'h9000_0000, 32'd0);
      push_event(CMD_UPDATE, 32'h900F_4240, 32'd0);
      push_event(CMD_GOAL, 32'h9010_0000, 32'h0000_8000);
      push_event(CMD_END, 32'h9020_0000, 32'd0);
      push_event(CMD_UPDATE, 32'h9040_0000, 32'd0);
      push_event(CMD_UPDATE, 32'hA000_0000, 32'd0);
      push_event(CMD_BEGIN, 32'hFFFF_FF00, 32'd0);
      push_event(CMD_UPDATE, 32'h0000_0100, 32'd0);
      push_event(CMD_BRAKE, 32'h0000_0200, 32'd0);
      push_event(CMD_UPDATE, 32'h0000_0300, 32'd0);
      for (int c = CMD_BRAKE + 1; c < 8; c++) push_event(CMD_W'(c), $urandom, $urandom);
      drain_results();

      phase = 0;
      while (issued < TOTAL_EVENTS) begin
         case (phase)
            0: program_rates('0, '0, '0);
            1: program_rates('1, '1, '1);
            2: program_rates('1, '1, '0);
            3: program_rates('0, '1, 32'h0000_0100);
            default: program_rates(rand_magnitude(), rand_magnitude(),
                                   $urandom >> $urandom_range(4, 31));
         endcase
         if (phase % 3 == 1) long_hold_request = 1'b1;
         phase_start = issued;
         while (issued - phase_start < PHASE_EVENTS && issued < TOTAL_EVENTS)
            push_ramp_episode();
         drain_results();
         phase++;
      end

      repeat (80) @(negedge clock);
      if (error_count == 0) begin
         $display("tb_speed_ramp_generator_unit: PASS");
      end else begin
         $display("tb_speed_ramp_generator_unit: FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire
